// File: hw/rtl/adaa_tanh_distortion_assert.svh
// assertion helpers for the waveshaper, clocked on clk with reset rst_n
`ifndef ADAA_TANH_DISTORTION_ASSERT_SVH
`define ADAA_TANH_DISTORTION_ASSERT_SVH

// same-cycle implication
`define ADAA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ADAA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/adaa_pkg.sv
// ----------------------------------------------------------------------------
// adaa_pkg
// Shared types and fixed constants of the antialiased tanh waveshaper.
// ----------------------------------------------------------------------------
package adaa_pkg;

  // fixed field widths
  localparam int LEVEL_W   = 17;
  localparam int TIDX_W    = 10;
  localparam int USER_W    = 3;
  localparam int CFG_DW    = 32;
  localparam int CFG_AW    = 2;
  localparam int LIMIT_W   = 23;
  localparam int FRAC_BITS = 20;
  localparam int POS_FRAC  = 16;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'd65536;

  // register reset values
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 23'd4194304;
  localparam logic [CFG_DW-1:0]  SCALE_RST  = 32'd16760832;
  localparam logic [LIMIT_W-1:0] SDELTA_RST = 23'd1;

  typedef enum logic [1:0] {
    ACT_SAMPLE  = 2'd0,
    ACT_LOAD_SH = 2'd1,
    ACT_LOAD_AD = 2'd2
  } action_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_LIMIT  = 2'd0,
    CFG_SCALE  = 2'd1,
    CFG_SDELTA = 2'd2
  } cfg_idx_t;

  typedef enum logic {
    PH_AD = 1'b0,
    PH_SH = 1'b1
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FP,
    ST_F0,
    ST_TMUL,
    ST_TADDR,
    ST_TRD0,
    ST_TRD1,
    ST_TINT,
    ST_TFIN,
    ST_SEL,
    ST_DIV,
    ST_MIX0,
    ST_MIX1,
    ST_MIX2,
    ST_OUT
  } state_t;

endpackage

// File: hw/rtl/adaa_ram.sv
// ----------------------------------------------------------------------------
// adaa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module adaa_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/adaa_div.sv
// ----------------------------------------------------------------------------
// adaa_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module adaa_div #(
  parameter int NW = 45,
  parameter int DW = 25
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [DW-1:0]    rem_r, rem_nxt;
  logic [NW-1:0]    quo_r, quo_nxt;
  logic [DW-1:0]    den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DW:0]      shifted;
  logic [DW:0]      trial;

  // one compare and subtract step
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[NW-1]};
    trial    = shifted - {1'b0, den_r};
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = num;
      den_nxt  = den;
      cnt_nxt  = CNT_W'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = trial[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

// File: hw/rtl/adaa_tanh_distortion.sv
// ----------------------------------------------------------------------------
// adaa_tanh_distortion
// First-order antiderivative-antialiased tanh waveshaper with dry/wet mix.
// ----------------------------------------------------------------------------
// A table load transfer leaves the block idle. Every product comes from one
// shift-add multiplier that retires one multiplier bit per cycle: the table
// position, the interpolation, and each of the two mix terms. The antialiased
// quotient comes from a restoring divider that retires one quotient bit per
// cycle. The longest case takes two full table reads, or one full table read
// and the divide. The shortest case is an input beyond the limit on the
// shaper path with a clamped table position. Samples are handled one at a
// time. The result waits in an output register, and the next transfer can be
// taken in the cycle after the result enters that register. A result that
// has not been taken stalls the next sample only in its final cycle. Both
// tables must be loaded before samples that read them are sent.
module adaa_tanh_distortion #(
  parameter int CHANNELS    = 2,
  parameter int TABLE_DEPTH = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: sample_in, level, table_index, table_value, zero pad
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((2*SAMPLE_BITS+adaa_pkg::LEVEL_W+adaa_pkg::TIDX_W+7)/8)*8-1:0] in_tdata,
  // in_tuser: action[1:0], channel
  input  logic [adaa_pkg::USER_W-1:0] in_tuser,
  // out_tdata: sample_out
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0] out_tdata,
  // out_tuser: channel_out
  output logic out_tuser,
  input  logic cfg_we,
  input  logic [adaa_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [adaa_pkg::CFG_DW-1:0] cfg_wdata
);

  import adaa_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int OUT_DW = ((SB + 7) / 8) * 8;
  localparam int MW     = SB + CFG_DW + 3;
  localparam int MBW    = (SB > LEVEL_W) ? SB : LEVEL_W;
  localparam int MCW    = $clog2(MBW + 1);
  localparam int NW     = SB + 1 + FRAC_BITS;
  localparam int DW     = SB + 1;
  localparam int POS_W  = SB + CFG_DW - FRAC_BITS;
  localparam int IDX_W  = POS_W - POS_FRAC;

  localparam logic signed [MW-1:0] SAT_HI = MW'((64'sd1 <<< (SB - 1)) - 64'sd1);
  localparam logic signed [MW-1:0] SAT_LO = -SAT_HI - MW'(1);
  localparam logic [NW-1:0] Q_MIN_MAG = NW'(64'd1 << (SB - 1));
  localparam logic [AW-1:0] LAST_IDX  = AW'(TABLE_DEPTH - 1);

  function automatic logic signed [SB-1:0] f_sat(input logic signed [MW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SAT_HI) r = SAT_HI[SB-1:0];
    else if (v < SAT_LO) r = SAT_LO[SB-1:0];
    else r = v[SB-1:0];
    return r;
  endfunction

  // input field split
  logic [1:0]             in_act;
  logic                   in_ch;
  logic signed [SB-1:0]   in_x;
  logic [LEVEL_W-1:0]     in_level;
  logic [TIDX_W-1:0]      in_tidx;
  logic [SB-1:0]          in_tval;
  logic                   in_xfer;

  assign in_act   = in_tuser[1:0];
  assign in_ch    = in_tuser[2];
  assign in_x     = in_tdata[SB-1:0];
  assign in_level = in_tdata[SB +: LEVEL_W];
  assign in_tidx  = in_tdata[SB+LEVEL_W +: TIDX_W];
  assign in_tval  = in_tdata[SB+LEVEL_W+TIDX_W +: SB];
  assign in_xfer  = in_tvalid && in_tready;

  // configuration registers
  logic [LIMIT_W-1:0] limit_r;
  logic [CFG_DW-1:0]  scale_r;
  logic [LIMIT_W-1:0] sdelta_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= LIMIT_RST;
      scale_r  <= SCALE_RST;
      sdelta_r <= SDELTA_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LIMIT:  limit_r  <= cfg_wdata[LIMIT_W-1:0];
        CFG_SCALE:  scale_r  <= cfg_wdata;
        CFG_SDELTA: sdelta_r <= cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // state and datapath registers
  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic signed [SB-1:0] prev_x_r  [CHANNELS];
  logic signed [SB-1:0] prev_ad_r [CHANNELS];
  logic [CHANNELS-1:0]  fresh_r;
  logic                 hist_we;

  logic signed [SB-1:0] x_r, x_nxt;
  logic [CW-1:0]        ch_r, ch_nxt;
  logic [LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic [SB-1:0]        magx_r, magx_nxt;
  logic signed [SB-1:0] fp_r, fp_nxt;
  logic signed [SB-1:0] fx_r, fx_nxt;
  logic signed [SB-1:0] wet_r, wet_nxt;
  logic signed [SB-1:0] t0_r, t0_nxt;
  logic signed [SB-1:0] res_r, res_nxt;
  logic [AW-1:0]        idx_r, idx_nxt;
  logic                 clamp_r, clamp_nxt;
  logic                 qneg_r, qneg_nxt;

  // serial multiplier
  logic signed [MW-1:0] mul_a_r, mul_a_nxt;
  logic [MBW-1:0]       mul_b_r, mul_b_nxt;
  logic signed [MW-1:0] acc_r, acc_nxt;
  logic [MCW-1:0]       mcnt_r, mcnt_nxt;
  logic                 mul_busy;
  logic signed [MW-1:0] acc_step;

  assign mul_busy = (mcnt_r != '0);
  assign acc_step = acc_r + (mul_b_r[0] ? mul_a_r : '0);

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic signed [SB-1:0] out_data_r, out_data_nxt;
  logic                 out_ch_r, out_ch_nxt;

  // tables
  logic                 sh_we, ad_we;
  logic [AW-1:0]        raddr;
  logic [SB-1:0]        sh_rdata, ad_rdata;
  logic signed [SB-1:0] t_rdata;

  adaa_ram #(.WIDTH(SB), .DEPTH(TABLE_DEPTH)) u_sh_ram (
    .clk   (clk),
    .we    (sh_we),
    .waddr (AW'(in_tidx)),
    .wdata (in_tval),
    .raddr (raddr),
    .rdata (sh_rdata)
  );

  adaa_ram #(.WIDTH(SB), .DEPTH(TABLE_DEPTH)) u_ad_ram (
    .clk   (clk),
    .we    (ad_we),
    .waddr (AW'(in_tidx)),
    .wdata (in_tval),
    .raddr (raddr),
    .rdata (ad_rdata)
  );

  assign t_rdata = (phase_r == PH_AD) ? ad_rdata : sh_rdata;

  // divider
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] div_num;
  logic [DW-1:0] div_den;
  logic [NW-1:0] div_quo;

  adaa_div #(.NW(NW), .DW(DW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // derived values
  logic [POS_W-1:0]     pos;
  logic [IDX_W-1:0]     pos_idx;
  logic signed [SB:0]   delta;
  logic [SB:0]          magd;
  logic signed [SB:0]   fdiff;
  logic [SB:0]          fmag;
  logic signed [SB-1:0] tres;
  logic signed [SB:0]   tdiff;

  assign pos     = acc_r[FRAC_BITS +: POS_W];
  assign pos_idx = pos[POS_FRAC +: IDX_W];
  assign delta   = (SB+1)'(x_r) - (SB+1)'(prev_x_r[ch_r]);
  assign magd    = delta[SB] ? -delta : delta;
  assign fdiff   = (SB+1)'(fx_r) - (SB+1)'(fp_r);
  assign fmag    = fdiff[SB] ? -fdiff : fdiff;
  assign tres    = t0_r + SB'(acc_r >>> POS_FRAC);
  assign tdiff   = (SB+1)'(t_rdata) - (SB+1)'(t0_r);
  assign div_num = {fmag, {FRAC_BITS{1'b0}}};
  assign div_den = magd;

  // next state and datapath
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    x_nxt         = x_r;
    ch_nxt        = ch_r;
    lvl_nxt       = lvl_r;
    magx_nxt      = magx_r;
    fp_nxt        = fp_r;
    fx_nxt        = fx_r;
    wet_nxt       = wet_r;
    t0_nxt        = t0_r;
    res_nxt       = res_r;
    idx_nxt       = idx_r;
    clamp_nxt     = clamp_r;
    qneg_nxt      = qneg_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    acc_nxt       = acc_r;
    mcnt_nxt      = mcnt_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_ch_nxt    = out_ch_r;
    in_tready     = 1'b0;
    sh_we         = 1'b0;
    ad_we         = 1'b0;
    raddr         = '0;
    div_start     = 1'b0;
    hist_we       = 1'b0;

    // multiplier step while counting
    if (mul_busy) begin
      acc_nxt   = acc_step;
      mul_a_nxt = mul_a_r <<< 1;
      mul_b_nxt = mul_b_r >> 1;
      mcnt_nxt  = mcnt_r - 1'b1;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          case (in_act)
            ACT_LOAD_SH: sh_we = (32'(in_tidx) < TABLE_DEPTH);
            ACT_LOAD_AD: ad_we = (32'(in_tidx) < TABLE_DEPTH);
            ACT_SAMPLE: begin
              if (32'(in_ch) < CHANNELS) begin
                x_nxt     = in_x;
                ch_nxt    = CW'(in_ch);
                lvl_nxt   = (in_level > LEVEL_ONE) ? LEVEL_ONE : in_level;
                magx_nxt  = in_x[SB-1] ? SB'(-in_x) : SB'(in_x);
                state_nxt = ST_FP;
              end
            end
            default: ;
          endcase
        end
      end
      // read the first antiderivative entry for a fresh channel
      ST_FP: begin
        raddr     = '0;
        state_nxt = ST_F0;
      end
      ST_F0: begin
        fp_nxt = fresh_r[ch_r] ? $signed(ad_rdata) : prev_ad_r[ch_r];
        if (32'(magx_r) > 32'(limit_r)) begin
          fx_nxt    = f_sat(MW'(magx_r));
          state_nxt = ST_SEL;
        end else begin
          phase_nxt = PH_AD;
          mul_a_nxt = MW'(scale_r);
          mul_b_nxt = MBW'(magx_r);
          acc_nxt   = '0;
          mcnt_nxt  = MCW'(SB);
          state_nxt = ST_TMUL;
        end
      end
      // table position = magnitude * scale
      ST_TMUL: begin
        if (!mul_busy) begin
          clamp_nxt = (32'(pos_idx) >= TABLE_DEPTH - 1);
          idx_nxt   = (32'(pos_idx) >= TABLE_DEPTH - 1) ? LAST_IDX : AW'(pos_idx);
          mul_b_nxt = MBW'(pos[POS_FRAC-1:0]);
          state_nxt = ST_TADDR;
        end
      end
      ST_TADDR: begin
        raddr     = idx_r;
        state_nxt = ST_TRD0;
      end
      ST_TRD0: begin
        t0_nxt = t_rdata;
        raddr  = idx_r + 1'b1;
        if (clamp_r) begin
          acc_nxt   = '0;
          state_nxt = ST_TFIN;
        end else begin
          state_nxt = ST_TRD1;
        end
      end
      // interpolation step times fraction
      ST_TRD1: begin
        mul_a_nxt = MW'(tdiff);
        acc_nxt   = '0;
        mcnt_nxt  = MCW'(POS_FRAC);
        state_nxt = ST_TINT;
      end
      ST_TINT: begin
        if (!mul_busy) begin
          state_nxt = ST_TFIN;
        end
      end
      ST_TFIN: begin
        if (phase_r == PH_AD) begin
          fx_nxt    = tres;
          state_nxt = ST_SEL;
        end else begin
          wet_nxt   = x_r[SB-1] ? f_sat(-MW'(tres)) : tres;
          state_nxt = ST_MIX0;
        end
      end
      // shaper for small changes, quotient otherwise
      ST_SEL: begin
        if (delta == '0 || 32'(magd) < 32'(sdelta_r)) begin
          phase_nxt = PH_SH;
          mul_a_nxt = MW'(scale_r);
          mul_b_nxt = MBW'(magx_r);
          acc_nxt   = '0;
          mcnt_nxt  = MCW'(SB);
          state_nxt = ST_TMUL;
        end else begin
          div_start = 1'b1;
          qneg_nxt  = fdiff[SB] ^ delta[SB];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          if (qneg_r) begin
            wet_nxt = (div_quo > Q_MIN_MAG) ? SAT_LO[SB-1:0] : SB'(-div_quo);
          end else begin
            wet_nxt = (div_quo > Q_MIN_MAG - 1'b1) ? SAT_HI[SB-1:0] : SB'(div_quo);
          end
          state_nxt = ST_MIX0;
        end
      end
      // level * wet + (one - level) * dry
      ST_MIX0: begin
        mul_a_nxt = MW'(wet_r);
        mul_b_nxt = MBW'(lvl_r);
        acc_nxt   = '0;
        mcnt_nxt  = MCW'(LEVEL_W);
        state_nxt = ST_MIX1;
      end
      ST_MIX1: begin
        if (!mul_busy) begin
          mul_a_nxt = MW'(x_r);
          mul_b_nxt = MBW'(LEVEL_ONE - lvl_r);
          mcnt_nxt  = MCW'(LEVEL_W);
          state_nxt = ST_MIX2;
        end
      end
      ST_MIX2: begin
        if (!mul_busy) begin
          res_nxt   = f_sat(acc_r >>> POS_FRAC);
          hist_we   = 1'b1;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          out_ch_nxt    = ch_r[0];
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      mcnt_r      <= mcnt_nxt;
    end
  end

  // channel history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prev_x_r[c]  <= '0;
        prev_ad_r[c] <= '0;
      end
      fresh_r <= '1;
    end else if (hist_we) begin
      prev_x_r[ch_r]  <= x_r;
      prev_ad_r[ch_r] <= fx_r;
      fresh_r[ch_r]   <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    x_r        <= x_nxt;
    ch_r       <= ch_nxt;
    lvl_r      <= lvl_nxt;
    magx_r     <= magx_nxt;
    fp_r       <= fp_nxt;
    fx_r       <= fx_nxt;
    wet_r      <= wet_nxt;
    t0_r       <= t0_nxt;
    res_r      <= res_nxt;
    idx_r      <= idx_nxt;
    clamp_r    <= clamp_nxt;
    qneg_r     <= qneg_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
    out_ch_r   <= out_ch_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'(out_data_r);
  assign out_tuser  = out_ch_r;

  // checks
  `include "adaa_tanh_distortion_assert.svh"

  `ADAA_ASSERT_IMP(a_out_from_done, $rose(out_valid_r), $past(state_r) == ST_OUT, "result not from finish state")
  `ADAA_ASSERT_NXT(a_load_stays_idle, in_xfer && (in_act == ACT_LOAD_SH || in_act == ACT_LOAD_AD), state_r == ST_IDLE, "table load left idle")
  `ADAA_ASSERT_NXT(a_sample_starts, in_xfer && in_act == ACT_SAMPLE && 32'(in_ch) < CHANNELS, state_r == ST_FP, "sample did not start")

endmodule
